FILE: hdl/ppc_pkg.sv
// shared types, widths and codes for the positional pid controller
// no dependencies; imported by every module under hdl

package ppc_pkg;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_FRAC = 8;
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ACT_W     = 2;

  // derived datapath widths
  localparam int ERR_W   = SAMPLE_W + 1;
  localparam int DERR_W  = SAMPLE_W + 2;
  localparam int SUMX_W  = ((REG_W > ERR_W) ? REG_W : ERR_W) + 2;
  localparam int PP_W    = REG_W + 1 + ERR_W;
  localparam int DP_W    = REG_W + 1 + DERR_W;
  localparam int IP_W    = 2 * REG_W;
  localparam int P_W     = PP_W - GAIN_FRAC;
  localparam int D_W     = DP_W - GAIN_FRAC;
  localparam int IS_W    = IP_W - GAIN_FRAC;
  localparam int TOT_W   = ((P_W > D_W) ? P_W : D_W) + 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_COMPUTE   = 2'd0,
    ACT_CLEAR_ALL = 2'd1,
    ACT_CLEAR_SUM = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_ILIM = 3'd3,
    CFG_OLIM = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] kp;
    logic [REG_W-1:0] ki;
    logic [REG_W-1:0] kd;
    logic [REG_W-1:0] ilim;
    logic [REG_W-1:0] olim;
  } cfg_t;

  // error stage -> term stage
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic        [REG_W-1:0]  sum;
    logic signed [DERR_W-1:0] derr;
  } err_stage_t;

  // term stage -> output stage
  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic        [REG_W-1:0] i;
    logic signed [D_W-1:0] d;
  } term_stage_t;

endpackage

FILE: hdl/positional_pid_clamped.sv
// top level of the positional pid controller: configuration registers and
// the three-stage pipeline; depends on ppc_pkg, ppc_err_stage,
// ppc_term_stage and ppc_out_stage

// usage
//   input channel (in_valid / in_stall): one transaction carries an action,
//   a target and a measured sample. compute transactions give one drive
//   value; clear-all and clear-sum transactions update state only and give
//   no result. the unused action code is accepted and ignored.
//   result channel (out_valid / out_stall): one drive value per compute
//   transaction, in order.
//   configuration: cfg_we writes cfg_wdata into the register at cfg_index
//   (kp, ki, kd, integral limit, output limit); other indexes are ignored.
//   write only while no transaction is in flight.
// timing
//   a compute transaction is registered in the front, middle and back stages
//   before it shows on out_valid; one transaction per cycle is sustained
//   while out_stall is low. the error sum and previous error close their
//   loop inside the front stage, which is what sets that rate; the gain
//   multipliers sit in the middle stage, the output clamp in the last.
// reset and stall
//   synchronous active-low reset clears the gains, limits, controller state
//   and all valid flags. a stalled result holds; bubbles ahead of it keep
//   filling, and in_stall rises only once every stage is occupied.

module positional_pid_clamped import ppc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [SAMPLE_W-1:0]  in_target,
  input  logic [SAMPLE_W-1:0]  in_measured,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [REG_W-1:0]     out_drive,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  cfg_t        cfg_r;

  logic        s1_ready;
  logic        s1_valid;
  err_stage_t  s1_data;
  logic        s2_ready;
  logic        s2_valid;
  term_stage_t s2_data;
  logic        s3_ready;

  // configuration registers, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:   cfg_r.kp   <= cfg_wdata;
        CFG_KI:   cfg_r.ki   <= cfg_wdata;
        CFG_KD:   cfg_r.kd   <= cfg_wdata;
        CFG_ILIM: cfg_r.ilim <= cfg_wdata;
        CFG_OLIM: cfg_r.olim <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // front: error, clamped sum, delta, state update
  ppc_err_stage u_err (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_action   (in_action),
    .in_target   (in_target),
    .in_measured (in_measured),
    .ilim        (cfg_r.ilim),
    .ready_i     (s2_ready),
    .ready_o     (s1_ready),
    .valid_o     (s1_valid),
    .data_o      (s1_data)
  );

  // middle: three gain products
  ppc_term_stage u_term (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .cfg     (cfg_r),
    .ready_i (s3_ready),
    .ready_o (s2_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  // back: sum, clamp, result register
  ppc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (s2_valid),
    .data_i    (s2_data),
    .olim      (cfg_r.olim),
    .out_stall (out_stall),
    .ready_o   (s3_ready),
    .out_valid (out_valid),
    .out_drive (out_drive)
  );

  assign in_stall = !s1_ready;

  // non-compute transactions never enter the term pipeline
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action != ACT_COMPUTE) |=> !s1_valid)
    else $error("state-only transaction produced a pipeline entry");

endmodule

FILE: hdl/ppc_err_stage.sv
// front stage: error, clamped error sum, error delta and controller state
// depends on ppc_pkg

module ppc_err_stage import ppc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [SAMPLE_W-1:0] in_target,
  input  logic [SAMPLE_W-1:0] in_measured,
  input  logic [REG_W-1:0]    ilim,
  input  logic                ready_i,
  output logic                ready_o,
  output logic                valid_o,
  output err_stage_t          data_o
);

  logic                     s1_valid_r;
  err_stage_t               s1_data_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic        [REG_W-1:0]  error_sum_r;

  logic                     accept;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUMX_W-1:0] sum_raw;
  logic signed [SUMX_W-1:0] sum_top;
  logic signed [SUMX_W-1:0] lim_x;
  logic        [REG_W-1:0]  sum_new;
  logic signed [DERR_W-1:0] derr;

  assign ready_o = !s1_valid_r || ready_i;
  assign accept  = in_valid && ready_o;

  always_comb begin
    err     = $signed(ERR_W'($signed(in_target))) - $signed(ERR_W'($signed(in_measured)));
    lim_x   = $signed(SUMX_W'(ilim));
    sum_raw = $signed(SUMX_W'(error_sum_r)) + $signed(SUMX_W'(err));
    // upper clamp first, then floor at zero
    sum_top = (sum_raw >= lim_x) ? lim_x : sum_raw;
    if (sum_top <= $signed(SUMX_W'(0))) begin
      sum_new = '0;
    end else begin
      sum_new = sum_top[REG_W-1:0];
    end
    derr = $signed(DERR_W'(err)) - $signed(DERR_W'(prev_err_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      prev_err_r  <= '0;
      error_sum_r <= '0;
    end else begin
      if (ready_o) begin
        s1_valid_r <= accept && (in_action == ACT_COMPUTE);
      end
      if (accept) begin
        case (in_action)
          ACT_COMPUTE: begin
            error_sum_r <= sum_new;
            prev_err_r  <= err;
          end
          ACT_CLEAR_ALL: begin
            error_sum_r <= '0;
            prev_err_r  <= '0;
          end
          ACT_CLEAR_SUM: begin
            error_sum_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_action == ACT_COMPUTE)) begin
      s1_data_r.err  <= err;
      s1_data_r.sum  <= sum_new;
      s1_data_r.derr <= derr;
    end
  end

  assign valid_o = s1_valid_r;
  assign data_o  = s1_data_r;

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_CLEAR_ALL) |=> (error_sum_r == '0 && prev_err_r == '0))
    else $error("clear-all transaction left controller state nonzero");

  a_clear_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_CLEAR_SUM) |=> (error_sum_r == '0 && $stable(prev_err_r)))
    else $error("clear-sum transaction mishandled controller state");

  a_compute_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_COMPUTE) |=> (error_sum_r == s1_data_r.sum && s1_valid_r))
    else $error("stored error sum differs from forwarded sum");

endmodule

FILE: hdl/ppc_term_stage.sv
// middle stage: gain products, fixed-point floor shift, integral term clamp
// depends on ppc_pkg

module ppc_term_stage import ppc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  err_stage_t  data_i,
  input  cfg_t        cfg,
  input  logic        ready_i,
  output logic        ready_o,
  output logic        valid_o,
  output term_stage_t data_o
);

  logic                   s2_valid_r;
  term_stage_t            s2_data_r;

  logic signed [PP_W-1:0] p_prod;
  logic signed [DP_W-1:0] d_prod;
  logic        [IP_W-1:0] i_prod;
  logic        [IS_W-1:0] i_shift;
  logic        [REG_W-1:0] i_clamp;

  assign ready_o = !s2_valid_r || ready_i;

  always_comb begin
    p_prod  = $signed({1'b0, cfg.kp}) * $signed(data_i.err);
    d_prod  = $signed({1'b0, cfg.kd}) * $signed(data_i.derr);
    i_prod  = cfg.ki * data_i.sum;
    i_shift = i_prod[IP_W-1:GAIN_FRAC];
    // product is never negative, so only the upper bound can bite
    if (i_shift > IS_W'(cfg.ilim)) begin
      i_clamp = cfg.ilim;
    end else begin
      i_clamp = i_shift[REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (ready_o) begin
      s2_valid_r <= valid_i;
    end
  end

  // dropping the low bits of a two's complement product is a floor shift
  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      s2_data_r.p <= p_prod[PP_W-1:GAIN_FRAC];
      s2_data_r.i <= i_clamp;
      s2_data_r.d <= d_prod[DP_W-1:GAIN_FRAC];
    end
  end

  assign valid_o = s2_valid_r;
  assign data_o  = s2_data_r;

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_i && ready_o) |=> s2_valid_r)
    else $error("term stage dropped a transaction");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !ready_i) |=> (s2_valid_r && $stable(s2_data_r)))
    else $error("term stage changed while blocked");

endmodule

FILE: hdl/ppc_out_stage.sv
// last stage: sum of terms, output clamp and the result register
// depends on ppc_pkg

module ppc_out_stage import ppc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  term_stage_t      data_i,
  input  logic [REG_W-1:0] olim,
  input  logic             out_stall,
  output logic             ready_o,
  output logic             out_valid,
  output logic [REG_W-1:0] out_drive
);

  logic                    out_valid_r;
  logic [REG_W-1:0]        out_drive_r;
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] olim_x;
  logic signed [TOT_W-1:0] total_top;
  logic [REG_W-1:0]        drive_nxt;

  assign ready_o = !out_valid_r || !out_stall;

  always_comb begin
    total = $signed(TOT_W'($signed(data_i.p)))
          + $signed(TOT_W'(data_i.i))
          + $signed(TOT_W'($signed(data_i.d)));
    olim_x    = $signed(TOT_W'(olim));
    total_top = (total > olim_x) ? olim_x : total;
    if (total_top <= $signed(TOT_W'(0))) begin
      drive_nxt = '0;
    end else begin
      drive_nxt = total_top[REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_o) begin
      out_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      out_drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

endmodule

FILE: verif/pid_drive_checker.sv
`timescale 1ns / 100ps
// drive-value checker for positional_pid_clamped: mirrors the gain and limit
// registers, predicts each drive value and compares it; depends on ppc_pkg

module pid_drive_checker import ppc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [SAMPLE_W-1:0]  in_target,
  input  logic [SAMPLE_W-1:0]  in_measured,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [REG_W-1:0]     out_drive,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   pending,
  output int                   drives_checked,
  output int                   items_taken
);

  logic [REG_W-1:0] gain_p, gain_i, gain_d, sum_limit, drive_limit;
  longint           last_err, err_acc;
  logic [REG_W-1:0] drive_expected[$];

  // one controller step; returns 1 when the transaction yields a drive value
  function automatic bit pid_step(input logic [ACT_W-1:0] act,
                                  input logic [SAMPLE_W-1:0] tgt,
                                  input logic [SAMPLE_W-1:0] meas,
                                  output logic [REG_W-1:0] drive);
    longint err, acc, p_term, i_term, d_term, total;
    drive = '0;
    case (act)
      ACT_CLEAR_ALL: begin
        err_acc  = 0;
        last_err = 0;
        return 1'b0;
      end
      ACT_CLEAR_SUM: begin
        err_acc = 0;
        return 1'b0;
      end
      ACT_COMPUTE: ;
      default: return 1'b0;
    endcase
    err = longint'($signed(tgt)) - longint'($signed(meas));
    // upper clamp first, then anything not positive goes to zero
    acc = err_acc + err;
    if (acc >= longint'(sum_limit)) acc = longint'(sum_limit);
    if (acc <= 0) acc = 0;
    err_acc = acc;
    p_term = (longint'(gain_p) * err) >>> GAIN_FRAC;
    i_term = (longint'(gain_i) * acc) >>> GAIN_FRAC;
    if (i_term > longint'(sum_limit)) i_term = longint'(sum_limit);
    if (i_term < -longint'(sum_limit)) i_term = -longint'(sum_limit);
    d_term = (longint'(gain_d) * (err - last_err)) >>> GAIN_FRAC;
    last_err = err;
    total = p_term + i_term + d_term;
    if (total > longint'(drive_limit)) total = longint'(drive_limit);
    if (total <= 0) total = 0;
    drive = total[REG_W-1:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    logic [REG_W-1:0] want;
    if (!rst_n) begin
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
      sum_limit = '0;
      drive_limit = '0;
      last_err = 0;
      err_acc = 0;
      drive_expected.delete();
      mismatch_count = 0;
      drives_checked = 0;
      items_taken = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_expected.size() == 0) begin
          $display("%0t: drive %0d arrived with nothing expected", $time, out_drive);
          mismatch_count++;
        end else begin
          want = drive_expected.pop_front();
          drives_checked++;
          if (out_drive !== want) begin
            $display("%0t: drive mismatch, expected %0d, actual %0d",
                     $time, want, out_drive);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KP:   gain_p = cfg_wdata;
          CFG_KI:   gain_i = cfg_wdata;
          CFG_KD:   gain_d = cfg_wdata;
          CFG_ILIM: sum_limit = cfg_wdata;
          CFG_OLIM: drive_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        items_taken++;
        if (pid_step(in_action, in_target, in_measured, want))
          drive_expected.push_back(want);
      end
    end
    pending = drive_expected.size();
  end

endmodule

FILE: verif/tb_positional_pid_clamped.sv
`timescale 1ns / 100ps
// testbench top for positional_pid_clamped: clock, reset, stimulus, idling
// and verdict; depends on ppc_pkg, the block and pid_drive_checker

module tb_positional_pid_clamped import ppc_pkg::*; ();

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 650;
  localparam int SEGMENTS       = 8;
  localparam int HOLD_LEN       = 40;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  // codes the block must accept and ignore
  localparam logic [ACT_W-1:0]     ACT_UNUSED  = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = CFG_IDX_W'(CFG_OLIM + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action;
  logic [SAMPLE_W-1:0]  in_target;
  logic [SAMPLE_W-1:0]  in_measured;
  logic                 out_valid;
  logic                 out_stall;
  logic [REG_W-1:0]     out_drive;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  int mismatch_count, pending, drives_checked, items_taken;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_requests = 0;
  int settings_used = 1;  // the reset values count as the first setting
  int idle_run      = 0;

  positional_pid_clamped u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_target   (in_target),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  pid_drive_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_target      (in_target),
    .in_measured    (in_measured),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive      (out_drive),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .drives_checked (drives_checked),
    .items_taken    (items_taken)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog: ends the run if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_run);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // receiver: random stall per cycle, plus a long hold-off on request
  initial begin : receiver
    int served;
    served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served++;
        // keep stalling while the sender keeps offering, so the pipe fills
        // and in_stall has to rise
        repeat (HOLD_LEN) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one transaction and return at the edge that accepts it; payload
  // and valid only change at falling edges, and stay put while stalled
  task automatic push_item(input logic [ACT_W-1:0] act,
                           input logic [SAMPLE_W-1:0] tgt,
                           input logic [SAMPLE_W-1:0] meas);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_target   <= tgt;
    in_measured <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid, wait for every drive value, then give clears in flight time
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one register write per cycle; cfg_we stays up across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // called at a falling edge while the block is idle
  task automatic apply_settings(input logic [REG_W-1:0] kp_v, input logic [REG_W-1:0] ki_v,
                                input logic [REG_W-1:0] kd_v, input logic [REG_W-1:0] ilim_v,
                                input logic [REG_W-1:0] olim_v);
    // writes to indexes past the last register must be dropped
    write_reg(CFG_NONE_LO, REG_W'($urandom()));
    write_reg(CFG_NONE_HI, REG_W'($urandom()));
    write_reg(CFG_KP, kp_v);
    write_reg(CFG_KI, ki_v);
    write_reg(CFG_KD, kd_v);
    write_reg(CFG_ILIM, ilim_v);
    write_reg(CFG_OLIM, olim_v);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // register value: mostly moderate, sometimes full range or an extreme
  function automatic logic [REG_W-1:0] pick_reg(input int moderate_max);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return REG_W'($urandom());
      default: return REG_W'($urandom_range(0, moderate_max));
    endcase
  endfunction

  task automatic run_random(input int count, input bit with_hold);
    int                  taken;
    int                  pick;
    bit                  hold_done;
    logic [ACT_W-1:0]    act;
    logic [SAMPLE_W-1:0] tgt, meas;
    taken = 0;
    hold_done = 1'b0;
    while (taken < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)       act = ACT_CLEAR_ALL;
      else if (pick < 11) act = ACT_CLEAR_SUM;
      else if (pick < 14) act = ACT_UNUSED;
      else                act = ACT_COMPUTE;
      tgt = SAMPLE_W'($urandom());
      case ($urandom_range(0, 3))
        0: meas = SAMPLE_W'($urandom());
        1: begin
          // full-scale swing in either direction
          tgt  = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          meas = ~tgt;
        end
        // measurement close to the setpoint keeps the sum off its clamps
        default: meas = tgt + 16'd300 - SAMPLE_W'($urandom_range(0, 600));
      endcase
      push_item(act, tgt, meas);
      if (act != ACT_UNUSED) taken++;
      if (with_hold && !hold_done && taken >= count / 4) begin
        hold_requests++;
        hold_done = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    int seg;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_COMPUTE;
    in_target   = '0;
    in_measured = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_KP;
    cfg_wdata   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all gains and limits still zero after reset: drive must be zero
    push_item(ACT_COMPUTE, 16'h1234, 16'h0034);
    settle();

    // directed part under unity-ish gains and mid limits
    apply_settings(16'd256, 16'd64, 16'd128, 16'd1000, 16'd30000);
    push_item(ACT_COMPUTE, 16'h0000, 16'h0000);
    push_item(ACT_COMPUTE, 16'h7fff, 16'h8000);  // largest positive error, sum hits limit
    push_item(ACT_COMPUTE, 16'h8000, 16'h7fff);  // largest negative error, sum floors at zero
    push_item(ACT_COMPUTE, 16'hffff, 16'h0000);
    push_item(ACT_COMPUTE, 16'h0000, 16'hffff);
    push_item(ACT_COMPUTE, 16'haaaa, 16'h5555);
    push_item(ACT_COMPUTE, 16'h5555, 16'haaaa);
    push_item(ACT_COMPUTE, 16'h7fff, 16'h0000);  // large positive error, output stays under the limit
    push_item(ACT_COMPUTE, 16'h0000, 16'h7fff);  // output clamps at zero
    push_item(ACT_CLEAR_ALL, 16'hffff, 16'hffff);
    push_item(ACT_COMPUTE, 16'd100, 16'd0);
    push_item(ACT_CLEAR_SUM, 16'h8000, 16'h7fff);
    push_item(ACT_COMPUTE, 16'd100, 16'd50);     // derivative still sees the old error
    push_item(ACT_UNUSED, 16'h7fff, 16'h8000);   // ignored code, state untouched
    push_item(ACT_COMPUTE, 16'd10, 16'd10);
    settle();

    // every register at its maximum: widest products
    apply_settings('1, '1, '1, '1, '1);
    push_item(ACT_COMPUTE, 16'h7fff, 16'h8000);
    push_item(ACT_COMPUTE, 16'h8000, 16'h7fff);
    push_item(ACT_COMPUTE, 16'h1234, 16'h1200);
    push_item(ACT_COMPUTE, 16'h0000, 16'h0000);
    settle();

    // random part: four idle patterns, two settings each, one long hold-off
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      apply_settings(pick_reg(768), pick_reg(768), pick_reg(768),
                     pick_reg(20000), pick_reg(20000));
      run_random(RANDOM_ITEMS / SEGMENTS, seg == 0);
      settle();
    end

    $display("covered %0d input transactions and %0d checked drive values", items_taken,
             drives_checked);
    $display("over %0d gain/limit settings, four idle patterns and a full-pipe hold-off",
             settings_used);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: positional_pid_clamped.f
hdl/ppc_pkg.sv
hdl/ppc_err_stage.sv
hdl/ppc_term_stage.sv
hdl/ppc_out_stage.sv
hdl/positional_pid_clamped.sv
verif/pid_drive_checker.sv
verif/tb_positional_pid_clamped.sv
